@@ design/msev_pkg.sv @@
// ----------------------------------------------------------------------------
// msev_pkg
// shared types and constants of the monotone spline evaluator
// ----------------------------------------------------------------------------
package msev_pkg;

    localparam int MSEV_MAX_KNOTS = 16;

    localparam int VAL_W   = 16;
    localparam int IDX_W   = 4;
    localparam int MODE_W  = 2;
    localparam int CFG_W   = 5;
    localparam int OUT_W   = 32;
    localparam int DIF_W   = 18;
    localparam int SQ_W    = 32;
    localparam int DEN_W   = 16;
    localparam int QUO_W   = 29;
    localparam int PSI_W   = 31;
    localparam int PROD_W  = 48;
    localparam int CNT_W   = 5;

    localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

    localparam logic [MODE_W-1:0] MODE_LOAD_KNOT = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LOAD_COEF = 2'd1;
    localparam logic [MODE_W-1:0] MODE_EVAL      = 2'd2;
    localparam logic [MODE_W-1:0] MODE_UNUSED    = 2'd3;

    typedef struct packed {
        logic signed [VAL_W-1:0] knot;
        logic signed [VAL_W-1:0] coef;
    } t_entry;

    typedef struct packed {
        logic load_knot;
        logic load_coef;
        logic shift;
    } t_cell_ctl;

endpackage

@@ design/monotone_spline_evaluator_core.sv @@
// ----------------------------------------------------------------------------
// monotone_spline_evaluator_core
// integrated linear b-spline evaluator over a rotating ring of table cells
// ----------------------------------------------------------------------------
// slave stream: tuser carries mode, tdata carries entry index and operand.
// mode 0 and 1 write one knot or coefficient slot, mode 2 evaluates g(x)
// and returns one master transaction, mode 3 is dropped.
// the knot and coefficient slots form a ring of cells; an evaluation rotates
// the ring one step per knot so the head cell presents knot l and its
// neighbor knot l+1, then rotates the rest of the way home.
// per knot, the serial divider (one quotient bit a cycle, 29 bits) runs only
// when a division is needed; the divider sets the rate. x below -1 finishes
// without walking the knots. one item is in work at a time; tready is high
// only between items, and a new item is taken while a result waits.
// a stalled master side holds the result register and the next evaluation
// waits for it before finishing. synchronous reset clears control and sets
// knots_in_use to 16; table contents stay undefined until written.
// ----------------------------------------------------------------------------
module monotone_spline_evaluator_core #(
    parameter int MAX_KNOTS = msev_pkg::MSEV_MAX_KNOTS
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [msev_pkg::CFG_W-1:0] i_cfg_wdata,
    input  logic                       i_s_axis_tvalid,
    output logic                       o_s_axis_tready,
    input  logic [23:0]                i_s_axis_tdata,  // entry_index, operand_value, pad
    input  logic [1:0]                 i_s_axis_tuser,  // mode
    output logic                       o_m_axis_tvalid,
    input  logic                       i_m_axis_tready,
    output logic [31:0]                o_m_axis_tdata,  // spline_value
    output logic [0:0]                 o_m_axis_tuser   // saturated
);
    import msev_pkg::*;

    localparam int LW    = $clog2(MAX_KNOTS + 1);
    localparam int ACC_W = PROD_W + $clog2(MAX_KNOTS) + 1;

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_SETUP = 9'b000000010,
        S_SQ    = 9'b000000100,
        S_DST   = 9'b000001000,
        S_DIV   = 9'b000010000,
        S_PSI   = 9'b000100000,
        S_MUL   = 9'b001000000,
        S_ACC   = 9'b010000000,
        S_HOME  = 9'b100000000
    } t_state;

    t_state r_state, n_state;
    logic   r_done_wait;

    logic [CFG_W-1:0]         r_cfg;
    logic [LW-1:0]            r_l;
    logic [LW-1:0]            r_rot;
    logic signed [DIF_W-1:0]  r_x;
    logic signed [DIF_W-1:0]  r_uprev;
    logic signed [DIF_W-1:0]  r_ul;
    logic [VAL_W-1:0]         r_sqop;
    logic [SQ_W-1:0]          r_sq;
    logic [DEN_W-1:0]         r_den;
    logic [PSI_W-1:0]         r_base;
    logic [PSI_W-1:0]         r_lin;
    logic                     r_neg;
    logic                     r_need;
    logic [PSI_W-1:0]         r_psi;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc;
    logic                     r_ovalid;
    logic [OUT_W-1:0]         r_odata;
    logic                     r_osat;

    logic [MODE_W-1:0]       w_mode;
    logic [IDX_W-1:0]        w_idx;
    logic signed [VAL_W-1:0] w_val;
    logic                    w_acc_in;
    logic [LW-1:0]           w_k;
    logic                    w_first;
    logic                    w_last;

    t_entry    w_cell [MAX_KNOTS];
    t_cell_ctl w_ctl  [MAX_KNOTS];

    logic signed [DIF_W-1:0] w_ul, w_dl, w_un, w_dr, w_a, w_b;
    logic                    w_dl_ok;
    logic [PSI_W-1:0]        w_base, w_lin;
    logic [VAL_W-1:0]        w_sqop;
    logic [DEN_W-1:0]        w_den;
    logic                    w_neg, w_need;

    logic [QUO_W-1:0]        w_quo;
    logic                    w_div_done;
    logic [PSI_W-1:0]        w_q;

    logic signed [63:0]      w_sum, w_rq;
    logic                    w_slot;

    assign w_mode   = i_s_axis_tuser;
    assign w_idx    = i_s_axis_tdata[IDX_W-1:0];
    assign w_val    = i_s_axis_tdata[IDX_W+VAL_W-1:IDX_W];
    assign o_s_axis_tready = (r_state == S_IDLE) && !r_done_wait;
    assign w_acc_in = i_s_axis_tvalid && o_s_axis_tready;

    always_comb begin
        if (r_cfg < 5'd2) begin
            w_k = LW'(2);
        end else if (int'(r_cfg) > MAX_KNOTS) begin
            w_k = LW'(MAX_KNOTS);
        end else begin
            w_k = LW'(r_cfg);
        end
    end

    assign w_first = (r_l == '0);
    assign w_last  = (r_l == w_k - LW'(1));

    for (genvar i = 0; i < MAX_KNOTS; i++) begin : g_cell
        always_comb begin
            w_ctl[i].shift     = (r_state == S_ACC) || (r_state == S_HOME);
            w_ctl[i].load_knot = w_acc_in && (w_mode == MODE_LOAD_KNOT) && (int'(w_idx) == i);
            w_ctl[i].load_coef = w_acc_in && (w_mode == MODE_LOAD_COEF) && (int'(w_idx) == i);
        end
        msev_cell u_cell (
            .i_clk       (i_clk),
            .i_ctl       (w_ctl[i]),
            .i_load_data (w_val),
            .i_nbr       (w_cell[(i + 1) % MAX_KNOTS]),
            .o_entry     (w_cell[i])
        );
    end

    always_comb begin
        w_ul    = w_first ? -18'sd16384
                          : {{(DIF_W-VAL_W){w_cell[0].knot[VAL_W-1]}}, w_cell[0].knot};
        w_un    = {{(DIF_W-VAL_W){w_cell[1].knot[VAL_W-1]}}, w_cell[1].knot};
        w_dl    = w_ul - r_uprev;
        w_dr    = w_last ? w_dl : (w_un - w_ul);
        w_a     = r_x - r_uprev;
        w_b     = r_x - w_ul;
        w_dl_ok = !w_first && (w_dl > 0);
        w_base  = '0;
        w_lin   = '0;
        w_neg   = 1'b0;
        w_need  = 1'b0;
        w_sqop  = w_a[VAL_W-1:0];
        w_den   = w_dl[DEN_W-1:0];
        if (r_x < w_ul) begin
            w_need = w_dl_ok && (w_a >= 0);
        end else begin
            if (w_dl_ok) begin
                w_base = PSI_W'({w_dl[DEN_W-1:0], 13'b0});
            end
            if (w_dr > 0) begin
                if (w_b >= w_dr) begin
                    w_base = w_base + PSI_W'({w_dr[DEN_W-1:0], 13'b0});
                end else begin
                    w_need = 1'b1;
                    w_neg  = 1'b1;
                    w_sqop = w_b[VAL_W-1:0];
                    w_den  = w_dr[DEN_W-1:0];
                    w_lin  = PSI_W'({w_b[VAL_W-1:0], 14'b0});
                end
            end
        end
    end

    msev_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_DST),
        .i_sq    (r_sq),
        .i_den   (r_den),
        .o_quo   (w_quo),
        .o_done  (w_div_done)
    );

    assign w_q = r_need ? PSI_W'(w_quo) : '0;

    always_comb begin
        w_sum = {{(64-ACC_W){r_acc[ACC_W-1]}}, r_acc} + 64'sd524288;
        w_rq  = w_sum >>> 20;
    end

    assign w_slot = !r_ovalid || i_m_axis_tready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_acc_in && (w_mode == MODE_EVAL) && (w_val >= -16'sd16384)) begin
                    n_state = S_SETUP;
                end
            end
            S_SETUP: n_state = w_need ? S_SQ : S_PSI;
            S_SQ:    n_state = S_DST;
            S_DST:   n_state = S_DIV;
            S_DIV:   n_state = w_div_done ? S_PSI : S_DIV;
            S_PSI:   n_state = S_MUL;
            S_MUL:   n_state = S_ACC;
            S_ACC: begin
                if (!w_last) begin
                    n_state = S_SETUP;
                end else if (w_k == LW'(MAX_KNOTS)) begin
                    n_state = S_IDLE;
                end else begin
                    n_state = S_HOME;
                end
            end
            S_HOME:  n_state = (r_rot == LW'(1)) ? S_IDLE : S_HOME;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_done_wait <= 1'b0;
            r_cfg       <= CFG_RESET;
            r_ovalid    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_cfg <= i_cfg_wdata;
            end
            if ((r_state == S_IDLE) && w_acc_in && (w_mode == MODE_EVAL)
                && (w_val < -16'sd16384)) begin
                r_done_wait <= 1'b1;
            end else if ((r_state == S_ACC) && w_last && (w_k == LW'(MAX_KNOTS))) begin
                r_done_wait <= 1'b1;
            end else if ((r_state == S_HOME) && (r_rot == LW'(1))) begin
                r_done_wait <= 1'b1;
            end else if (r_done_wait && w_slot) begin
                r_done_wait <= 1'b0;
            end
            if (r_done_wait && w_slot) begin
                r_ovalid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (w_acc_in) begin
                    r_l     <= '0;
                    r_acc   <= '0;
                    r_uprev <= -18'sd16384;
                    r_x     <= (w_val > 16'sd16384) ? 18'sd16384
                                                    : {{(DIF_W-VAL_W){w_val[VAL_W-1]}}, w_val};
                end
            end
            S_SETUP: begin
                r_ul   <= w_ul;
                r_sqop <= w_sqop;
                r_den  <= w_den;
                r_base <= w_base;
                r_lin  <= w_lin;
                r_neg  <= w_neg;
                r_need <= w_need;
            end
            S_SQ:  r_sq   <= r_sqop * r_sqop;
            S_PSI: r_psi  <= r_neg ? (r_base + r_lin - w_q) : (r_base + w_q);
            S_MUL: r_prod <= $signed({1'b0, r_psi}) * w_cell[0].coef;
            S_ACC: begin
                r_acc   <= r_acc + ACC_W'(r_prod);
                r_uprev <= r_ul;
                r_l     <= r_l + LW'(1);
                r_rot   <= LW'(MAX_KNOTS) - w_k;
            end
            S_HOME: r_rot <= r_rot - LW'(1);
            default: begin
            end
        endcase
        if (r_done_wait && w_slot) begin
            if (w_rq > 64'sd2147483647) begin
                r_odata <= 32'h7fffffff;
                r_osat  <= 1'b1;
            end else if (w_rq < -64'sd2147483648) begin
                r_odata <= 32'h80000000;
                r_osat  <= 1'b1;
            end else begin
                r_odata <= w_rq[OUT_W-1:0];
                r_osat  <= 1'b0;
            end
        end
    end

    assign o_m_axis_tvalid   = r_ovalid;
    assign o_m_axis_tdata    = r_odata;
    assign o_m_axis_tuser[0] = r_osat;

endmodule

@@ design/msev_cell.sv @@
// ----------------------------------------------------------------------------
// msev_cell
// one table slot of the rotating knot and coefficient ring
// ----------------------------------------------------------------------------
module msev_cell (
    input  logic                       i_clk,
    input  msev_pkg::t_cell_ctl        i_ctl,
    input  logic [msev_pkg::VAL_W-1:0] i_load_data,
    input  msev_pkg::t_entry           i_nbr,
    output msev_pkg::t_entry           o_entry
);
    import msev_pkg::*;

    t_entry r_entry;

    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_entry <= i_nbr;
        end else begin
            if (i_ctl.load_knot) begin
                r_entry.knot <= i_load_data;
            end
            if (i_ctl.load_coef) begin
                r_entry.coef <= i_load_data;
            end
        end
    end

    assign o_entry = r_entry;

endmodule

@@ design/msev_div.sv @@
// ----------------------------------------------------------------------------
// msev_div
// radix-2 restoring divider, floor(sq * 2^13 / den), one quotient bit a cycle
// ----------------------------------------------------------------------------
module msev_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [msev_pkg::SQ_W-1:0]  i_sq,
    input  logic [msev_pkg::DEN_W-1:0] i_den,
    output logic [msev_pkg::QUO_W-1:0] o_quo,
    output logic                       o_done
);
    import msev_pkg::*;

    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic [QUO_W-1:0] r_shf;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [DEN_W:0]   w_t;
    logic [DEN_W:0]   w_diff;
    logic             w_ge;

    assign w_t    = {r_rem, r_shf[QUO_W-1]};
    assign w_ge   = w_t >= {1'b0, r_den};
    assign w_diff = w_t - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(QUO_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_sq[SQ_W-1:SQ_W-DEN_W];
            r_shf <= {i_sq[SQ_W-DEN_W-1:0], 13'b0};
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[DEN_W-1:0] : w_t[DEN_W-1:0];
            r_shf <= {r_shf[QUO_W-2:0], w_ge};
        end
    end

    assign o_quo  = r_shf;
    assign o_done = r_done;

endmodule

@@ design/msev_checker.sv @@
// ----------------------------------------------------------------------------
// msev_checker
// port-level checks of the monotone spline evaluator
// ----------------------------------------------------------------------------
module msev_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_cfg_we,
    input logic [4:0]  i_cfg_wdata,
    input logic        i_s_axis_tvalid,
    input logic        o_s_axis_tready,
    input logic [23:0] i_s_axis_tdata,
    input logic [1:0]  i_s_axis_tuser,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [31:0] o_m_axis_tdata,
    input logic [0:0]  o_m_axis_tuser
);
    import msev_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid
            && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("result changed while stalled");

    a_eval_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready && (i_s_axis_tuser == MODE_EVAL)
            |=> !o_s_axis_tready)
        else $error("ready after evaluate transaction");

    a_load_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready && (i_s_axis_tuser != MODE_EVAL)
            && !o_m_axis_tvalid |=> !o_m_axis_tvalid)
        else $error("result after load transaction");

    a_sat_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser[0] |->
            (o_m_axis_tdata == 32'h7fffffff) || (o_m_axis_tdata == 32'h80000000))
        else $error("saturated flag without limit value");

endmodule

bind monotone_spline_evaluator_core msev_checker u_msev_checker (.*);
